// ===== sv/spa_pkg.sv =====
package spa_pkg;

    localparam int POOL_BYTES  = 65536;
    localparam int MIN_BLOCK   = 16;
    localparam int NUM_CLASSES = 8;
    localparam int GRANULES    = POOL_BYTES / MIN_BLOCK;
    localparam int GRAN_W      = $clog2(GRANULES);
    localparam int OFS_W       = $clog2(MIN_BLOCK);
    localparam int CLS_W       = $clog2(NUM_CLASSES);
    localparam int ADDR_W      = 16;
    localparam int BYTES_W     = 12;
    localparam int CARVE_W     = 17;
    localparam int CNT_W       = 13;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REFRESH = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_REUSED  = 3'd0,
        ST_CARVED  = 3'd1,
        ST_SPLIT   = 3'd2,
        ST_EXCESS  = 3'd3,
        ST_FREED   = 3'd4,
        ST_DFREE   = 3'd5,
        ST_REINIT  = 3'd6,
        ST_SKIPPED = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_ALLOC,
        FSM_POP,
        FSM_SPLIT_HEAD,
        FSM_SPLIT_LOOP,
        FSM_FREE,
        FSM_EMIT
    } fsm_t;

    localparam logic CFG_POOL_KBYTES = 1'b0;
    localparam logic CFG_CLASS_COUNT = 1'b1;

    function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLS_W-1:0] k);
        class_bytes = BYTES_W'(MIN_BLOCK) << k;
    endfunction

endpackage

// ===== sv/segregated_pool_allocator_top.sv =====
// Pool allocator with eight power-of-two size classes from 16 bytes over a 64 KiB pool.
// Each request (allocate, free or refresh) gives one result, except opcode 3, which gives none.
// Requests are handled one at a time; a split writes its extra pieces one per cycle,
// bounded by the single write port of the link and tag memories. After reset and after
// each successful refresh the tag memory is cleared one granule per cycle, during which
// no request is taken; the refresh result follows that pass. Configuration writes take
// effect at the next refresh.
module segregated_pool_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // opcode[1:0], request_size[33:2], block_address[49:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // granted_address[15:0], granted_bytes[27:16], status[30:28]
);

    localparam int GW = spa_pkg::GRAN_W;
    localparam int CW = spa_pkg::CLS_W;
    localparam int NC = spa_pkg::NUM_CLASSES;

    spa_pkg::fsm_t state_reg, state_next;

    logic [6:0]  pool_kb_reg;
    logic [3:0]  class_cnt_reg;
    logic [3:0]  live_reg, live_next;
    logic [spa_pkg::CARVE_W-1:0] carve_reg, carve_next;
    logic [GW-1:0] head_reg [NC];
    logic [GW-1:0] head_next [NC];
    logic [NC-1:0] head_vld_reg, head_vld_next;
    logic [spa_pkg::CNT_W-1:0] outst_reg, outst_next;
    logic [GW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          emit_after_clr_reg, emit_after_clr_next;
    logic [CW-1:0] k_reg, k_next;
    logic          fit_reg, fit_next;
    logic [CW-1:0] j_reg, j_next;
    logic [GW-1:0] big_reg, big_next;
    logic [GW-1:0] piece_reg, piece_next;
    logic [7:0]    cnt_reg, cnt_next;
    logic [spa_pkg::ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [spa_pkg::BYTES_W-1:0] res_bytes_reg, res_bytes_next;
    spa_pkg::status_t            res_status_reg, res_status_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;

    logic [12:0] link_mem [spa_pkg::GRANULES];
    logic [3:0]  tag_mem  [spa_pkg::GRANULES];
    logic [12:0] link_rd_reg;
    logic [3:0]  tag_rd_reg;
    logic          link_we, tag_we;
    logic [GW-1:0] link_waddr, link_raddr, tag_waddr, tag_raddr;
    logic [12:0]   link_wdata;
    logic [3:0]    tag_wdata;

    logic [1:0]  in_op;
    logic [31:0] in_size;
    logic [15:0] in_baddr;
    logic        accept;
    logic        fit_c;
    logic [CW-1:0] fk_c;
    logic        jfound_c;
    logic [CW-1:0] j_c;
    logic [spa_pkg::BYTES_W-1:0] sz;
    logic [GW-1:0] step;
    logic [7:0]  last_cnt;
    logic [spa_pkg::CARVE_W-1:0] carve_sub;
    logic [spa_pkg::CARVE_W-1:0] pool_bytes_c;
    logic        out_free;

    assign in_op    = s_tdata[1:0];
    assign in_size  = s_tdata[33:2];
    assign in_baddr = s_tdata[49:34];
    assign s_tready = (state_reg == spa_pkg::FSM_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    assign sz        = spa_pkg::class_bytes(k_reg);
    assign step      = GW'(1) << k_reg;
    assign last_cnt  = (8'd1 << (j_reg - k_reg)) - 8'd1;
    assign carve_sub = carve_reg - spa_pkg::CARVE_W'(sz);
    assign pool_bytes_c = ({pool_kb_reg, 10'b0} > spa_pkg::CARVE_W'(spa_pkg::POOL_BYTES))
                        ? spa_pkg::CARVE_W'(spa_pkg::POOL_BYTES) : {pool_kb_reg, 10'b0};

    // Smallest live class that holds the request.
    always_comb
    begin
        fit_c = 1'b0;
        fk_c  = '0;
        for (int i = NC - 1; i >= 0; i--)
        begin
            if ((4'(i) < live_reg) &&
                (32'(spa_pkg::class_bytes(CW'(i))) >= in_size))
            begin
                fit_c = 1'b1;
                fk_c  = CW'(i);
            end
        end
    end

    // Lowest non-empty live class above the requested one.
    always_comb
    begin
        jfound_c = 1'b0;
        j_c      = '0;
        for (int i = NC - 1; i >= 0; i--)
        begin
            if ((CW'(i) > k_reg) && (4'(i) < live_reg) && head_vld_reg[i])
            begin
                jfound_c = 1'b1;
                j_c      = CW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spa_pkg::FSM_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        live_next           = live_reg;
        carve_next          = carve_reg;
        head_next           = head_reg;
        head_vld_next       = head_vld_reg;
        outst_next          = outst_reg;
        clr_cnt_next        = clr_cnt_reg;
        emit_after_clr_next = emit_after_clr_reg;
        k_next              = k_reg;
        fit_next            = fit_reg;
        j_next              = j_reg;
        big_next            = big_reg;
        piece_next          = piece_reg;
        cnt_next            = cnt_reg;
        res_addr_next       = res_addr_reg;
        res_bytes_next      = res_bytes_reg;
        res_status_next     = res_status_reg;
        m_valid_next        = m_valid_reg;
        m_data_next         = m_data_reg;
        link_we             = 1'b0;
        link_waddr          = '0;
        link_wdata          = '0;
        link_raddr          = '0;
        tag_we              = 1'b0;
        tag_waddr           = '0;
        tag_wdata           = '0;
        tag_raddr           = in_baddr[spa_pkg::OFS_W +: GW];

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            spa_pkg::FSM_CLEAR:
            begin
                tag_we       = 1'b1;
                tag_waddr    = clr_cnt_reg;
                tag_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + GW'(1);
                if (clr_cnt_reg == {GW{1'b1}})
                begin
                    state_next = emit_after_clr_reg ? spa_pkg::FSM_EMIT : spa_pkg::FSM_IDLE;
                end
            end

            spa_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    res_addr_next  = '0;
                    res_bytes_next = '0;
                    unique case (spa_pkg::op_t'(in_op))
                        spa_pkg::OP_ALLOC:
                        begin
                            k_next     = fk_c;
                            fit_next   = fit_c;
                            state_next = spa_pkg::FSM_ALLOC;
                        end
                        spa_pkg::OP_FREE:
                        begin
                            if (in_baddr[spa_pkg::OFS_W-1:0] != '0)
                            begin
                                res_status_next = spa_pkg::ST_DFREE;
                                state_next      = spa_pkg::FSM_EMIT;
                            end
                            else
                            begin
                                state_next = spa_pkg::FSM_FREE;
                            end
                        end
                        spa_pkg::OP_REFRESH:
                        begin
                            if (outst_reg == '0)
                            begin
                                carve_next          = pool_bytes_c;
                                live_next           = (class_cnt_reg > 4'(NC)) ? 4'(NC)
                                                                               : class_cnt_reg;
                                head_vld_next       = '0;
                                clr_cnt_next        = '0;
                                emit_after_clr_next = 1'b1;
                                res_status_next     = spa_pkg::ST_REINIT;
                                state_next          = spa_pkg::FSM_CLEAR;
                            end
                            else
                            begin
                                res_status_next = spa_pkg::ST_SKIPPED;
                                state_next      = spa_pkg::FSM_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = spa_pkg::FSM_IDLE;
                        end
                    endcase
                end
            end

            spa_pkg::FSM_ALLOC:
            begin
                if (!fit_reg)
                begin
                    res_status_next = spa_pkg::ST_EXCESS;
                    state_next      = spa_pkg::FSM_EMIT;
                end
                else if (head_vld_reg[k_reg])
                begin
                    link_raddr = head_reg[k_reg];
                    state_next = spa_pkg::FSM_POP;
                end
                else if (carve_reg > spa_pkg::CARVE_W'(sz))
                begin
                    carve_next      = carve_sub;
                    tag_we          = 1'b1;
                    tag_waddr       = carve_sub[spa_pkg::OFS_W +: GW];
                    tag_wdata       = {1'b1, k_reg};
                    outst_next      = outst_reg + spa_pkg::CNT_W'(1);
                    res_addr_next   = carve_sub[spa_pkg::ADDR_W-1:0];
                    res_bytes_next  = sz;
                    res_status_next = spa_pkg::ST_CARVED;
                    state_next      = spa_pkg::FSM_EMIT;
                end
                else if (jfound_c)
                begin
                    j_next     = j_c;
                    big_next   = head_reg[j_c];
                    link_raddr = head_reg[j_c];
                    state_next = spa_pkg::FSM_SPLIT_HEAD;
                end
                else
                begin
                    res_status_next = spa_pkg::ST_EXCESS;
                    state_next      = spa_pkg::FSM_EMIT;
                end
            end

            spa_pkg::FSM_POP:
            begin
                head_next[k_reg]    = link_rd_reg[GW-1:0];
                head_vld_next[k_reg] = !link_rd_reg[GW];
                tag_we              = 1'b1;
                tag_waddr           = head_reg[k_reg];
                tag_wdata           = {1'b1, k_reg};
                outst_next          = outst_reg + spa_pkg::CNT_W'(1);
                res_addr_next       = {head_reg[k_reg], {spa_pkg::OFS_W{1'b0}}};
                res_bytes_next      = sz;
                res_status_next     = spa_pkg::ST_REUSED;
                state_next          = spa_pkg::FSM_EMIT;
            end

            spa_pkg::FSM_SPLIT_HEAD:
            begin
                // The big block leaves its list; its lowest piece is granted.
                head_next[j_reg]     = link_rd_reg[GW-1:0];
                head_vld_next[j_reg] = !link_rd_reg[GW];
                link_we    = 1'b1;
                link_waddr = big_reg;
                link_wdata = {1'b0, big_reg + step};
                tag_we     = 1'b1;
                tag_waddr  = big_reg;
                tag_wdata  = {1'b1, k_reg};
                piece_next = big_reg + step;
                cnt_next   = 8'd1;
                state_next = spa_pkg::FSM_SPLIT_LOOP;
            end

            spa_pkg::FSM_SPLIT_LOOP:
            begin
                link_we    = 1'b1;
                link_waddr = piece_reg;
                link_wdata = (cnt_reg == last_cnt) ? {1'b1, {GW{1'b0}}}
                                                   : {1'b0, piece_reg + step};
                tag_we     = 1'b1;
                tag_waddr  = piece_reg;
                tag_wdata  = {1'b0, k_reg};
                piece_next = piece_reg + step;
                cnt_next   = cnt_reg + 8'd1;
                if (cnt_reg == last_cnt)
                begin
                    head_next[k_reg]     = big_reg + step;
                    head_vld_next[k_reg] = 1'b1;
                    outst_next           = outst_reg + spa_pkg::CNT_W'(1);
                    res_addr_next        = {big_reg, {spa_pkg::OFS_W{1'b0}}};
                    res_bytes_next       = sz;
                    res_status_next      = spa_pkg::ST_SPLIT;
                    state_next           = spa_pkg::FSM_EMIT;
                end
            end

            spa_pkg::FSM_FREE:
            begin
                if (tag_rd_reg[CW])
                begin
                    link_we    = 1'b1;
                    link_waddr = big_reg;
                    link_wdata = head_vld_reg[tag_rd_reg[CW-1:0]]
                               ? {1'b0, head_reg[tag_rd_reg[CW-1:0]]}
                               : {1'b1, {GW{1'b0}}};
                    head_next[tag_rd_reg[CW-1:0]]     = big_reg;
                    head_vld_next[tag_rd_reg[CW-1:0]] = 1'b1;
                    tag_we     = 1'b1;
                    tag_waddr  = big_reg;
                    tag_wdata  = {1'b0, tag_rd_reg[CW-1:0]};
                    if (outst_reg != '0)
                    begin
                        outst_next = outst_reg - spa_pkg::CNT_W'(1);
                    end
                    res_status_next = spa_pkg::ST_FREED;
                end
                else
                begin
                    res_status_next = spa_pkg::ST_DFREE;
                end
                state_next = spa_pkg::FSM_EMIT;
            end

            spa_pkg::FSM_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next        = 1'b1;
                    m_data_next         = {1'b0, res_status_reg, res_bytes_reg, res_addr_reg};
                    emit_after_clr_next = 1'b0;
                    state_next          = spa_pkg::FSM_IDLE;
                end
            end

            default:
            begin
                state_next = spa_pkg::FSM_IDLE;
            end
        endcase

        // The freed granule is kept in big_reg while its tag is read.
        if (accept && (spa_pkg::op_t'(in_op) == spa_pkg::OP_FREE))
        begin
            big_next = in_baddr[spa_pkg::OFS_W +: GW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_kb_reg        <= 7'd64;
            class_cnt_reg      <= 4'd8;
            live_reg           <= 4'(NC);
            carve_reg          <= spa_pkg::CARVE_W'(spa_pkg::POOL_BYTES);
            head_vld_reg       <= '0;
            outst_reg          <= '0;
            clr_cnt_reg        <= '0;
            emit_after_clr_reg <= 1'b0;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == spa_pkg::CFG_POOL_KBYTES))
            begin
                pool_kb_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == spa_pkg::CFG_CLASS_COUNT))
            begin
                class_cnt_reg <= cfg_wdata[3:0];
            end
            live_reg           <= live_next;
            carve_reg          <= carve_next;
            head_vld_reg       <= head_vld_next;
            outst_reg          <= outst_next;
            clr_cnt_reg        <= clr_cnt_next;
            emit_after_clr_reg <= emit_after_clr_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg       <= head_next;
        k_reg          <= k_next;
        fit_reg        <= fit_next;
        j_reg          <= j_next;
        big_reg        <= big_next;
        piece_reg      <= piece_next;
        cnt_reg        <= cnt_next;
        res_addr_reg   <= res_addr_next;
        res_bytes_reg  <= res_bytes_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rd_reg <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        tag_rd_reg <= tag_mem[tag_raddr];
    end

endmodule

// ===== sv/spa_checker.sv =====
module spa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_op,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic grant;

    assign grant = (m_tdata[30:28] == spa_pkg::ST_REUSED) ||
                   (m_tdata[30:28] == spa_pkg::ST_CARVED) ||
                   (m_tdata[30:28] == spa_pkg::ST_SPLIT);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // One request at a time: a request that gives a result blocks the next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_op != spa_pkg::OP_NONE) |=> !s_tready)
        else $error("request taken while another is in work");

    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !grant |-> m_tdata[27:0] == 28'd0)
        else $error("non-grant result carries address or size");

    a_grant_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && grant |-> $onehot(m_tdata[27:16]) && m_tdata[19:16] == 4'd0
                              && m_tdata[3:0] == 4'd0)
        else $error("granted block has bad size or alignment");

endmodule

bind segregated_pool_allocator_top spa_checker u_spa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_op     (s_tdata[1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/tb_segregated_pool_allocator_top.sv =====
module tb_segregated_pool_allocator_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 200;
    localparam int EMPTY      = -1;
    localparam int NCLS       = spa_pkg::NUM_CLASSES;
    localparam int NGRAN      = spa_pkg::GRANULES;
    localparam int MINB       = spa_pkg::MIN_BLOCK;

    typedef struct packed {
        logic [15:0]      addr;
        logic [11:0]      nbytes;
        spa_pkg::status_t st;
    } grant_t;

    typedef struct {
        spa_pkg::op_t op;
        logic [31:0]  size;
        logic [15:0]  addr;
        bit           typed;
        grant_t       res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [6:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    segregated_pool_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Shadow of the allocator state.
    int          pend_kbytes;
    int          pend_classes;
    int          live_classes;
    int          carve_top;
    int          free_head [NCLS];
    int          next_link [NGRAN];
    logic [4:0]  block_tag [NGRAN];
    int          outstanding;
    int          held_blocks [$];

    grant_t      grant_q [$];
    int          mismatches;
    int          idle_cycles;
    int          requests_sent;
    int          results_seen;
    int          splits_seen;
    int          reinits_seen;
    int          burst_left;
    int          stall_mode;

    always #5 clk = ~clk;

    function automatic void reinit_pool();
        int bytes;
        bytes = pend_kbytes * 1024;
        if (bytes > spa_pkg::POOL_BYTES)
            bytes = spa_pkg::POOL_BYTES;
        carve_top = bytes - (bytes % MINB);
        live_classes = (pend_classes > NCLS) ? NCLS : pend_classes;
        foreach (free_head[k])
            free_head[k] = EMPTY;
        foreach (block_tag[g])
        begin
            block_tag[g] = '0;
            next_link[g] = 0;
        end
        outstanding = 0;
        held_blocks.delete();
    endfunction

    function automatic void push_block(int k, int g);
        next_link[g] = free_head[k];
        free_head[k] = g;
        block_tag[g] = 5'(k);
    endfunction

    function automatic int pop_block(int k);
        int g;
        g = free_head[k];
        free_head[k] = next_link[g];
        block_tag[g] = 5'h10 | 5'(k);
        return g;
    endfunction

    function automatic grant_t allocator_step(spa_pkg::op_t op, logic [31:0] size,
                                              logic [15:0] addr);
        grant_t r;
        int k;
        int j;
        int g;
        int sz;
        int big;
        r = '{16'd0, 12'd0, spa_pkg::ST_EXCESS};
        case (op)
            spa_pkg::OP_ALLOC:
            begin
                for (k = 0; k < live_classes; k++)
                    if (longint'(MINB << k) >= longint'(size))
                        break;
                if (k < live_classes)
                begin
                    sz = MINB << k;
                    g = EMPTY;
                    if (free_head[k] != EMPTY)
                    begin
                        g = pop_block(k);
                        r.st = spa_pkg::ST_REUSED;
                    end
                    else if (carve_top > sz)
                    begin
                        carve_top -= sz;
                        g = carve_top / MINB;
                        block_tag[g] = 5'h10 | 5'(k);
                        r.st = spa_pkg::ST_CARVED;
                    end
                    else
                    begin
                        for (j = k + 1; j < live_classes; j++)
                            if (free_head[j] != EMPTY)
                                break;
                        if (j < live_classes)
                        begin
                            big = pop_block(j);
                            block_tag[big] = '0;
                            // Pieces go on in reverse so the lowest one ends up on top.
                            for (int i = (1 << (j - k)); i > 0; i--)
                                push_block(k, big + (i - 1) * (sz / MINB));
                            g = pop_block(k);
                            r.st = spa_pkg::ST_SPLIT;
                        end
                    end
                    if (g != EMPTY)
                    begin
                        outstanding++;
                        r.addr = 16'(g * MINB);
                        r.nbytes = 12'(sz);
                        held_blocks.push_back(g * MINB);
                    end
                end
            end
            spa_pkg::OP_FREE:
            begin
                r.st = spa_pkg::ST_DFREE;
                g = addr / MINB;
                if (addr % MINB == 0 && block_tag[g][4] && block_tag[g][3:0] < NCLS)
                begin
                    push_block(block_tag[g][3:0], g);
                    if (outstanding > 0)
                        outstanding--;
                    foreach (held_blocks[i])
                        if (held_blocks[i] == addr)
                        begin
                            held_blocks.delete(i);
                            break;
                        end
                    r.st = spa_pkg::ST_FREED;
                end
            end
            spa_pkg::OP_REFRESH:
            begin
                if (outstanding == 0)
                begin
                    reinit_pool();
                    r.st = spa_pkg::ST_REINIT;
                end
                else
                    r.st = spa_pkg::ST_SKIPPED;
            end
            default: ;
        endcase
        return r;
    endfunction

    // One request through the slave side; the prediction is made at acceptance.
    task automatic send_request(spa_pkg::op_t op, logic [31:0] size, logic [15:0] addr,
                                bit typed = 0, grant_t typed_res = '0);
        grant_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, addr, size, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = allocator_step(op, size, addr);
        if (op != spa_pkg::OP_NONE)
            grant_q.push_back(typed ? typed_res : r);
        if (r.st == spa_pkg::ST_SPLIT && op == spa_pkg::OP_ALLOC)
            splits_seen++;
        requests_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 15);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (grant_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE)
            @(negedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [6:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        pend_kbytes  = (idx == spa_pkg::CFG_POOL_KBYTES) ? int'(value) : pend_kbytes;
        pend_classes = (idx == spa_pkg::CFG_CLASS_COUNT) ? int'(value[3:0]) : pend_classes;
    endtask

    task automatic random_request();
        int pick;
        int k;
        logic [31:0] size;
        logic [15:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            k = $urandom_range(0, NCLS - 1);
            if ($urandom_range(0, 19) == 0)
                size = 32'($urandom);
            else
                size = 32'($urandom_range(0, MINB << k));
            send_request(spa_pkg::OP_ALLOC, size, 16'($urandom));
        end
        else if (pick < 92)
        begin
            if (held_blocks.size() != 0 && $urandom_range(0, 9) < 8)
                addr = 16'(held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
            else if ($urandom_range(0, 1) == 0)
                addr = 16'($urandom);
            else
                addr = 16'($urandom_range(0, NGRAN - 1) * MINB);
            send_request(spa_pkg::OP_FREE, 32'($urandom), addr);
        end
        else if (pick < 97)
            send_request(spa_pkg::OP_REFRESH, 32'($urandom), 16'($urandom));
        else
            send_request(spa_pkg::OP_NONE, 32'($urandom), 16'($urandom));
    endtask

    // Receiver readiness follows a mode that the stimulus changes now and then.
    always @(negedge clk)
    begin
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 2) != 0);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        grant_t want;
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            if (grant_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h at %0t", m_tdata, $realtime);
            end
            else
            begin
                want = grant_q.pop_front();
                if (m_tdata[15:0] !== want.addr || m_tdata[27:16] !== want.nbytes ||
                    m_tdata[30:28] !== want.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: addr %h/%h bytes %0d/%0d status %0d/%0d",
                                 want.addr, m_tdata[15:0], want.nbytes, m_tdata[27:16],
                                 want.st, m_tdata[30:28]);
                end
                if (want.st == spa_pkg::ST_REINIT)
                    reinits_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[segregated_pool_allocator_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        row_t rows [$];
        int phase_kb [8] = '{1, 127, 0, 64, 2, 1, 4, 64};
        int phase_cc [8] = '{8, 15, 8, 0, 3, 1, 8, 8};
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = spa_pkg::CFG_POOL_KBYTES;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b1;
        stall_mode = 0;
        mismatches = 0;
        idle_cycles = 0;
        requests_sent = 0;
        results_seen = 0;
        splits_seen = 0;
        reinits_seen = 0;
        burst_left = 10;
        pend_kbytes = 64;
        pend_classes = 8;
        reinit_pool();

        rows = '{
            '{spa_pkg::OP_ALLOC, 32'd0, 16'd0, 1,
              '{16'd65520, 12'd16, spa_pkg::ST_CARVED}},
            '{spa_pkg::OP_ALLOC, 32'd2048, 16'd0, 1,
              '{16'd63472, 12'd2048, spa_pkg::ST_CARVED}},
            '{spa_pkg::OP_ALLOC, 32'd2049, 16'd0, 1,
              '{16'd0, 12'd0, spa_pkg::ST_EXCESS}},
            '{spa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 16'd0, 1,
              '{16'd0, 12'd0, spa_pkg::ST_EXCESS}},
            '{spa_pkg::OP_FREE, 32'd0, 16'd65520, 1,
              '{16'd0, 12'd0, spa_pkg::ST_FREED}},
            '{spa_pkg::OP_FREE, 32'hFFFF_FFFF, 16'd65520, 1,
              '{16'd0, 12'd0, spa_pkg::ST_DFREE}},
            '{spa_pkg::OP_FREE, 32'd0, 16'd1, 1,
              '{16'd0, 12'd0, spa_pkg::ST_DFREE}},
            '{spa_pkg::OP_FREE, 32'd0, 16'hFFFF, 1,
              '{16'd0, 12'd0, spa_pkg::ST_DFREE}},
            '{spa_pkg::OP_ALLOC, 32'd16, 16'hFFFF, 1,
              '{16'd65520, 12'd16, spa_pkg::ST_REUSED}},
            '{spa_pkg::OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 0, '0},
            '{spa_pkg::OP_REFRESH, 32'd0, 16'd0, 1,
              '{16'd0, 12'd0, spa_pkg::ST_SKIPPED}},
            '{spa_pkg::OP_FREE, 32'd0, 16'd65520, 1,
              '{16'd0, 12'd0, spa_pkg::ST_FREED}},
            '{spa_pkg::OP_FREE, 32'd0, 16'd63472, 1,
              '{16'd0, 12'd0, spa_pkg::ST_FREED}},
            '{spa_pkg::OP_REFRESH, 32'd0, 16'd0, 1,
              '{16'd0, 12'd0, spa_pkg::ST_REINIT}},
            '{spa_pkg::OP_ALLOC, 32'd17, 16'd0, 1,
              '{16'd65504, 12'd32, spa_pkg::ST_CARVED}},
            '{spa_pkg::OP_ALLOC, 32'd1024, 16'd0, 0, '0},
            '{spa_pkg::OP_ALLOC, 32'd1025, 16'd0, 0, '0},
            '{spa_pkg::OP_FREE, 32'd0, 16'd0, 1,
              '{16'd0, 12'd0, spa_pkg::ST_DFREE}},
            '{spa_pkg::OP_FREE, 32'd0, 16'd65504, 0, '0},
            '{spa_pkg::OP_ALLOC, 32'd32, 16'd0, 0, '0}
        };

        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send_request(rows[i].op, rows[i].size, rows[i].addr, rows[i].typed, rows[i].res);

        for (int p = 0; p < 8; p++)
        begin
            // Return every held block so the refresh that latches the new setting succeeds.
            while (held_blocks.size() != 0)
                send_request(spa_pkg::OP_FREE, 32'd0, 16'(held_blocks[0]));
            wait_drained();
            write_cfg(spa_pkg::CFG_POOL_KBYTES, 7'(phase_kb[p]));
            write_cfg(spa_pkg::CFG_CLASS_COUNT, 7'(phase_cc[p]));
            send_request(spa_pkg::OP_REFRESH, 32'd0, 16'd0);
            stall_mode = p % 3;
            for (int n = 0; n < 185; n++)
            begin
                if (n % 60 == 59)
                    stall_mode = $urandom_range(0, 2);
                random_request();
            end
        end

        wait_drained();
        $display("%0d requests, %0d results, %0d splits, %0d pool reinits over 8 settings",
                 requests_sent, results_seen, splits_seen, reinits_seen);
        $display("pool sizes 0 to 127 KiB, class counts 0 to 15, %0d mismatches", mismatches);
        if (mismatches == 0 && grant_q.size() == 0)
            $display("[segregated_pool_allocator_top] OK");
        else
            $display("[segregated_pool_allocator_top] ERROR");
        $finish;
    end

endmodule
